[hw/rtl/rsc_pkg.sv]
// Shared types, constants and helper functions for the RPN stack calculator.
// No dependencies.
package rsc_pkg;

    localparam int VW    = 48;          // value width, Q31.16
    localparam int FB    = 16;          // fraction bits
    localparam int NUM_W = VW + FB;     // divider numerator width
    localparam int ACC_W = 2 * VW;      // product / quotient accumulator width

    localparam logic [2:0] OP_NUM  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_MOD  = 3'd5;
    localparam logic [2:0] OP_PRT  = 3'd6;
    localparam logic [2:0] OP_UNK  = 3'd7;

    typedef logic signed [VW-1:0] value_t;

    typedef struct packed {
        logic [2:0] req_type;
        value_t     number_value;
    } token_t;

    typedef struct packed {
        logic       print_valid;
        value_t     printed_value;
        logic       divide_by_zero;
        logic       stack_overflow;
        logic [1:0] empty_pops;
        logic       unknown_command;
    } result_t;

    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [NUM_W-1:0] num;
        logic [VW-1:0]    den;
    } md_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] acc;
        logic [VW-1:0]    rem;
    } md_rsp_t;

    localparam value_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam value_t VMIN = {1'b1, {(VW-1){1'b0}}};

    function automatic logic [VW-1:0] mag(input value_t v);
        mag = v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    // Saturate a sign and magnitude pair back into the signed range.
    function automatic value_t pack_sat(input logic neg, input logic [ACC_W-1:0] m);
        logic [ACC_W-1:0] lim;
        logic [VW-1:0]    lo;
        lim = {{(ACC_W-VW){1'b0}}, 1'b0, {(VW-1){1'b1}}} + {{(ACC_W-1){1'b0}}, neg};
        lo  = m[VW-1:0];
        if (m > lim)
            pack_sat = neg ? VMIN : VMAX;
        else
            pack_sat = neg ? value_t'(~lo + 1'b1) : value_t'(lo);
    endfunction

endpackage

[hw/rtl/rsc_stack_mem.sv]
// Operand stack storage: one write port, two registered read ports.
// Depends on rsc_pkg.
module rsc_stack_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  rsc_pkg::value_t     wdata,
    input  logic [AW-1:0]       raddr0,
    input  logic [AW-1:0]       raddr1,
    output rsc_pkg::value_t     rdata0,
    output rsc_pkg::value_t     rdata1
);
    import rsc_pkg::*;

    value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[hw/rtl/rsc_muldiv.sv]
// Shared radix-2 unit: shift-add multiply and restoring divide on magnitudes.
// Depends on rsc_pkg.
module rsc_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  rsc_pkg::md_req_t  req,
    output logic              busy,
    output rsc_pkg::md_rsp_t  rsp
);
    import rsc_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic             div_reg;
    logic [NUM_W-1:0] sh_reg;
    logic [VW-1:0]    den_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [VW:0]      rem_reg, rem_next;
    logic             bit_in;
    logic [VW:0]      r2;
    logic             ge;

    always_comb
    begin
        bit_in = sh_reg[NUM_W-1];
        r2     = {rem_reg[VW-1:0], bit_in};
        ge     = r2 >= {1'b0, den_reg};
        if (div_reg)
        begin
            acc_next = {acc_reg[ACC_W-2:0], ge};
            rem_next = ge ? (r2 - {1'b0, den_reg}) : r2;
        end
        else
        begin
            acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                     + (bit_in ? {{(ACC_W-VW){1'b0}}, den_reg} : '0);
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.is_div ? CW'(NUM_W) : CW'(VW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.is_div;
            // multiplier bits sit at the top so both modes shift from the MSB
            sh_reg  <= req.is_div ? req.num : (req.num << FB);
            den_reg <= req.den;
            acc_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[NUM_W-2:0], 1'b0};
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;
    assign rsp.rem  = rem_reg[VW-1:0];

endmodule

[hw/rtl/rpn_stack_calculator.sv]
// RPN calculator core: operand stack in a two-read-port memory, iterative mul/div.
// Each item passes through read and done states, plus a calc state on the shared
// radix-2 unit for multiply, divide and modulo; divide or modulo by zero skips it.
// Items are taken one at a time: a new token is accepted only once the last item is
// through. A held result stalls the next item.
// Reset (rst_n, async, active low) empties the stack; stack contents are not cleared.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             token_valid,
    output logic             token_ready,
    input  rsc_pkg::token_t  token,
    output logic             result_valid,
    input  logic             result_ready,
    output rsc_pkg::result_t result
);
    import rsc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    st_reg;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] dpop_reg;
    logic [2:0]    type_reg;
    value_t        num_reg;
    value_t        res_reg;
    logic          push_reg, neg_reg;
    result_t       pend_reg;
    logic          out_valid_reg;
    result_t       out_reg;

    value_t        rd0, rd1;
    md_req_t       md_req;
    md_rsp_t       md_rsp;
    logic          md_busy;

    // read stage decode
    logic          b_emp, a_emp, dz;
    value_t        bv, av;
    logic [VW-1:0] ma, mb, ia, ib;
    logic [1:0]    pops;
    logic [DW-1:0] dpop;
    logic          do_push, use_md;
    value_t        imm_res;
    logic [VW:0]   sum;
    logic          slot_free;

    assign token_ready = (st_reg == S_IDLE);
    assign slot_free   = !out_valid_reg || result_ready;

    rsc_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
        .clk    (clk),
        .we     (st_reg == S_DONE && slot_free && push_reg && dpop_reg != FULL),
        .waddr  (dpop_reg[AW-1:0]),
        .wdata  (res_reg),
        .raddr0 (AW'(depth_reg - 1'b1)),
        .raddr1 (AW'(depth_reg - 2'd2)),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    rsc_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .busy  (md_busy),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        b_emp = (depth_reg == '0);
        a_emp = (depth_reg <= DW'(1));
        bv    = b_emp ? '0 : rd0;
        av    = a_emp ? '0 : rd1;
        ma    = mag(av);
        mb    = mag(bv);
        ia    = ma >> FB;
        ib    = mb >> FB;
        dz      = 1'b0;
        pops    = 2'd0;
        do_push = 1'b0;
        use_md  = 1'b0;
        imm_res = num_reg;
        sum     = '0;
        case (type_reg)
            OP_NUM:
            begin
                do_push = 1'b1;
            end
            OP_ADD, OP_SUB:
            begin
                pops    = 2'd2;
                do_push = 1'b1;
                sum = (type_reg == OP_ADD) ? ({av[VW-1], av} + {bv[VW-1], bv})
                                           : ({av[VW-1], av} - {bv[VW-1], bv});
                if (sum[VW] != sum[VW-1])
                    imm_res = sum[VW] ? VMIN : VMAX;
                else
                    imm_res = value_t'(sum[VW-1:0]);
            end
            OP_MUL:
            begin
                pops    = 2'd2;
                do_push = 1'b1;
                use_md  = 1'b1;
            end
            OP_DIV:
            begin
                dz      = (bv == '0);
                pops    = dz ? 2'd1 : 2'd2;
                do_push = !dz;
                use_md  = !dz;
            end
            OP_MOD:
            begin
                dz      = (ib == '0);
                pops    = 2'd2;
                do_push = !dz;
                use_md  = !dz;
            end
            OP_PRT:
            begin
                pops    = 2'd1;
            end
            default:
            begin
                pops    = 2'd0;
            end
        endcase
        case (pops)
            2'd0:    dpop = depth_reg;
            2'd1:    dpop = b_emp ? depth_reg : depth_reg - 1'b1;
            default: dpop = a_emp ? '0 : depth_reg - 2'd2;
        endcase

        md_req.start  = (st_reg == S_READ) && use_md;
        md_req.is_div = (type_reg != OP_MUL);
        md_req.num    = (type_reg == OP_DIV) ? ({{FB{1'b0}}, ma} << FB)
                      : {{FB{1'b0}}, (type_reg == OP_MOD) ? ia : mb};
        md_req.den    = (type_reg == OP_DIV) ? mb : (type_reg == OP_MOD) ? ib : ma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == S_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (token_valid)
                        st_reg <= S_READ;
                S_READ:
                    st_reg <= use_md ? S_CALC : S_DONE;
                S_CALC:
                    if (md_rsp.done)
                        st_reg <= S_DONE;
                S_DONE:
                    if (slot_free)
                    begin
                        st_reg        <= S_IDLE;
                        depth_reg     <= (push_reg && dpop_reg != FULL) ? dpop_reg + 1'b1
                                                                        : dpop_reg;
                    end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && token_valid)
        begin
            type_reg <= token.req_type;
            num_reg  <= token.number_value;
        end
        if (st_reg == S_READ)
        begin
            dpop_reg <= dpop;
            push_reg <= do_push;
            res_reg  <= imm_res;
            neg_reg  <= (type_reg == OP_MOD) ? av[VW-1] : (av[VW-1] != bv[VW-1]);
            pend_reg.print_valid     <= (type_reg == OP_PRT);
            pend_reg.printed_value   <= (type_reg == OP_PRT) ? bv : '0;
            pend_reg.divide_by_zero  <= dz;
            pend_reg.stack_overflow  <= do_push && dpop == FULL;
            pend_reg.empty_pops      <= ((pops != 2'd0) ? {1'b0, b_emp} : 2'd0)
                                      + ((pops == 2'd2) ? {1'b0, a_emp} : 2'd0);
            pend_reg.unknown_command <= (type_reg == OP_UNK);
        end
        if (st_reg == S_CALC && md_rsp.done)
        begin
            case (type_reg)
                OP_MUL:  res_reg <= pack_sat(neg_reg, md_rsp.acc >> FB);
                OP_DIV:  res_reg <= pack_sat(neg_reg, md_rsp.acc);
                default: res_reg <= pack_sat(neg_reg,
                                    {{(ACC_W-VW){1'b0}}, md_rsp.rem << FB});
            endcase
        end
        if (st_reg == S_DONE && slot_free)
            out_reg <= pend_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= FULL)
        else $error("stack depth beyond capacity");
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_IDLE |-> !md_busy)
        else $error("arithmetic unit busy while idle");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.divide_by_zero && result.stack_overflow))
        else $error("divide by zero and overflow in one item");
    a_unk_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.unknown_command |->
            result.empty_pops == 2'd0 && !result.print_valid)
        else $error("unknown command touched the stack");
`endif

endmodule

[sim/tb_rpn_stack_calculator.sv]
// Testbench for the RPN stack calculator core: directed and random token streams.
// Depends on rsc_pkg and rpn_stack_calculator; predicts each result in-bench.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;
    import rsc_pkg::*;

    localparam int DEPTH = 128;
    localparam longint LIMIT = 2000000;

    logic    clk;
    logic    rst_n;
    logic    token_valid;
    logic    token_ready;
    token_t  token;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .token_valid(token_valid), .token_ready(token_ready), .token(token),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    // predictor state
    logic signed [63:0] calc_stack [DEPTH];
    int                 calc_depth;
    result_t            expected_q[$];

    int     mismatches;
    int     rx_wait;
    longint cycle_count;
    logic   rx_stall_en;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [63:0] vmax64();
        return 64'sd140737488355327;
    endfunction

    function automatic logic signed [63:0] vmin64();
        return -64'sd140737488355328;
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [127:0] v);
        if (v > 128'(vmax64()))
            return vmax64();
        if (v < 128'(vmin64()))
            return vmin64();
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] pop_value(inout int empties);
        if (calc_depth > 0)
        begin
            calc_depth--;
            return calc_stack[calc_depth];
        end
        empties++;
        return 0;
    endfunction

    function automatic logic push_value(input logic signed [63:0] v);
        if (calc_depth < DEPTH)
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // truncating signed division/remainder on 128-bit values
    function automatic result_t compute_result(input token_t t);
        result_t r;
        int empties;
        logic signed [63:0] a, b;
        logic signed [127:0] wide, q;
        logic [63:0] ia, ib;
        r = '0;
        empties = 0;
        case (t.req_type)
            OP_NUM: r.stack_overflow = push_value(64'(t.number_value));
            OP_ADD, OP_SUB, OP_MUL:
            begin
                b = pop_value(empties);
                a = pop_value(empties);
                if (t.req_type == OP_ADD)
                    wide = 128'(a) + 128'(b);
                else if (t.req_type == OP_SUB)
                    wide = 128'(a) - 128'(b);
                else
                begin
                    wide = 128'(a) * 128'(b);
                    // shift magnitude so rounding is toward zero
                    wide = (wide < 0) ? -((-wide) >>> FB) : (wide >>> FB);
                end
                r.stack_overflow = push_value(clamp(wide));
            end
            OP_DIV:
            begin
                b = pop_value(empties);
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    a = pop_value(empties);
                    q = (128'(a) <<< FB) / 128'(b);
                    r.stack_overflow = push_value(clamp(q));
                end
            end
            OP_MOD:
            begin
                b = pop_value(empties);
                a = pop_value(empties);
                ia = ((a < 0) ? -a : a) >> FB;
                ib = ((b < 0) ? -b : b) >> FB;
                if (ib == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    wide = 128'((ia % ib) << FB);
                    r.stack_overflow = push_value((a < 0) ? -wide[63:0] : wide[63:0]);
                end
            end
            OP_PRT:
            begin
                r.print_valid = 1'b1;
                r.printed_value = value_t'(pop_value(empties));
            end
            default: r.unknown_command = 1'b1;
        endcase
        r.empty_pops = 2'(empties);
        return r;
    endfunction

    // valid stays up across a zero gap; the next item replaces the payload
    task automatic send_token(input logic [2:0] kind, input value_t val);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            token_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        token_valid <= 1'b1;
        token.req_type <= kind;
        token.number_value <= val;
        @(posedge clk);
        while (!token_ready)
            @(posedge clk);
        expected_q.push_back(compute_result('{req_type: kind, number_value: val}));
    endtask

    task automatic wait_drained();
        token_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic value_t rand_value();
        case ($urandom_range(0, 5))
            0: return VMAX;
            1: return VMIN;
            2: return value_t'($signed($urandom_range(0, 40)) - 20) <<< FB;
            3: return value_t'({$urandom, $urandom});
            4: return value_t'($signed($urandom_range(0, 255)) - 128) <<< $urandom_range(0, 20);
            default: return value_t'($signed({$urandom} >> $urandom_range(8, 31)));
        endcase
    endfunction

    task automatic test_directed();
        send_token(OP_PRT, 0);                       // print on empty stack
        send_token(OP_ADD, 0);                       // two empty pops
        send_token(OP_PRT, 0);
        send_token(OP_NUM, VMAX);
        send_token(OP_NUM, 48'sd1 <<< FB);
        send_token(OP_ADD, 0);                       // saturates high
        send_token(OP_NUM, VMIN);
        send_token(OP_SUB, 0);
        send_token(OP_PRT, 0);
        send_token(OP_NUM, -(48'sd3 <<< FB));
        send_token(OP_NUM, 48'sd2 <<< FB);
        send_token(OP_MUL, 0);
        send_token(OP_NUM, 0);
        send_token(OP_DIV, 0);                       // divide by zero keeps dividend
        send_token(OP_NUM, 48'sd7);
        send_token(OP_DIV, 0);
        send_token(OP_NUM, -(48'sd17 <<< FB));
        send_token(OP_NUM, 48'sd5 <<< FB);
        send_token(OP_MOD, 0);
        send_token(OP_NUM, 48'sd100);
        send_token(OP_MOD, 0);                       // fractional divisor counts as zero
        send_token(OP_UNK, 48'sh5555_5555_5555);
        send_token(OP_PRT, 0);
    endtask

    task automatic test_overflow();
        repeat (DEPTH + 3)
            send_token(OP_NUM, rand_value());
        repeat (DEPTH + 2)
            send_token(OP_PRT, 0);
        wait_drained();                              // sender holds off until drained
    endtask

    task automatic test_random(input int count);
        int depth_goal;
        logic [2:0] kind;
        repeat (count)
        begin
            depth_goal = $urandom_range(0, 99);
            if (calc_depth < 2 && depth_goal < 70)
                kind = OP_NUM;
            else
                kind = 3'($urandom_range(0, 7));
            send_token(kind, rand_value());
            if ($urandom_range(0, 60) == 0)
                wait_drained();                      // sender holds off until drained
        end
    endtask

    // result checker; the receiver draws a wait per item when stalling is on
    always @(posedge clk)
    begin
        result_t exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                rx_wait = rx_stall_en ? int'($urandom_range(0, 19)) : 0;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", result);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, result);
                    end
                end
            end
            if (rx_wait > 0)
            begin
                result_ready <= 1'b0;
                rx_wait--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        token_valid = 1'b0;
        token = '0;
        result_ready = 1'b0;
        rx_stall_en = 1'b0;
        rx_wait = 0;
        cycle_count = 0;
        mismatches = 0;
        calc_depth = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        rx_stall_en <= 1'b1;
        test_overflow();
        test_random(100);
        rx_stall_en <= 1'b0;
        test_random(70);
        rx_stall_en <= 1'b1;
        test_random(100);
        wait_drained();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
